@@ design/tabx_pkg.sv @@
// ----------------------------------------------------------------------------
// tabx_pkg: shared types and constants of the tab expander
// Character codes, register indexes, reset values and the structs that carry
// configuration and results between the sequencer and the top level.
// ----------------------------------------------------------------------------
package tabx_pkg;

  localparam int REG_BITS        = 12;
  localparam int COUNT_BITS      = 12;
  localparam int CHAR_BITS       = 8;
  localparam int STOP_CNT_BITS   = 3;
  localparam int CFG_INDEX_BITS  = 3;
  localparam int IN_TDATA_BITS   = 8;
  localparam int OUT_TDATA_BITS  = 24;

  localparam int NUM_STOPS_DEF   = 4;
  localparam int COLUMN_BITS_DEF = 12;
  localparam int NUM_STOP_REGS   = 4;
  localparam int BASE_GRID       = 4;

  localparam logic [CHAR_BITS-1:0] TAB_CHAR     = 8'd9;
  localparam logic [CHAR_BITS-1:0] NEWLINE_CHAR = 8'd10;
  localparam logic [CHAR_BITS-1:0] SPACE_CHAR   = 8'd32;

  // register indexes on the configuration port
  localparam logic [CFG_INDEX_BITS-1:0] REG_STOP_0       = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_STOP_COUNT   = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_REPEAT_START = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_REPEAT_STEP  = 3'd6;

  localparam logic [REG_BITS-1:0] REPEAT_START_RST = 12'd2000;
  localparam logic [REG_BITS-1:0] REPEAT_STEP_RST  = 12'd4;

  typedef struct packed {
    logic [STOP_CNT_BITS-1:0] stop_count;
    logic [REG_BITS-1:0]      repeat_start;
    logic [REG_BITS-1:0]      repeat_step;
  } cfg_t;

  typedef struct packed {
    logic                     sat;
    logic [COUNT_BITS-1:0]    count;
    logic [CHAR_BITS-1:0]     ch;
  } res_t;

endpackage

@@ design/tabx_sub.sv @@
// ----------------------------------------------------------------------------
// tabx_sub: shared subtract and compare unit
// Gives a - b and a borrow flag; the borrow is set when b is above a.
// ----------------------------------------------------------------------------
module tabx_sub #(
  parameter int W = 14
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic [W-1:0] diff,
  output logic         borrow
);

  assign {borrow, diff} = {1'b0, a} - {1'b0, b};

endmodule

@@ design/tabx_seq.sv @@
// ----------------------------------------------------------------------------
// tabx_seq: tab stop sequencer
// Scans the explicit stops, then works out the grid stop, using one shared
// subtractor for the stop compares and for a bit-serial remainder.
// ----------------------------------------------------------------------------
module tabx_seq #(
  parameter int NUM_STOPS   = tabx_pkg::NUM_STOPS_DEF,
  parameter int COLUMN_BITS = tabx_pkg::COLUMN_BITS_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         in_valid,
  output logic                                         in_ready,
  input  logic [tabx_pkg::CHAR_BITS-1:0]               in_char,
  input  logic [NUM_STOPS-1:0][tabx_pkg::REG_BITS-1:0] stops,
  input  tabx_pkg::cfg_t                               cfg,
  output logic                                         res_valid,
  output tabx_pkg::res_t                               res,
  input  logic                                         res_take
);

  localparam int CW = COLUMN_BITS;
  localparam int RB = tabx_pkg::REG_BITS;
  localparam int XW = ((CW > RB) ? CW : RB) + 2;
  localparam int IW = (NUM_STOPS > 1) ? $clog2(NUM_STOPS) : 1;
  localparam int NW = $clog2(NUM_STOPS + 1);
  localparam int BW = (CW > 1) ? $clog2(CW) : 1;
  localparam logic [CW-1:0] COL_MAX   = '1;
  localparam logic [XW-1:0] COL_MAX_X = {{(XW-CW){1'b0}}, COL_MAX};

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SCAN = 6'b000010,
    S_GRID = 6'b000100,
    S_DIV  = 6'b001000,
    S_ADJ  = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

  state_t         state;
  logic           done;
  logic [CW-1:0]  column;
  logic [IW-1:0]  idx;
  logic [RB-1:0]  base;
  logic [XW-1:0]  target;
  logic [CW-1:0]  dq;
  logic [RB-1:0]  rem;
  logic [BW-1:0]  cnt;

  logic [NW-1:0]  n_eff;
  logic [XW-1:0]  cur_x, base_x, rs_x, step_x, stop_x;
  logic [XW-1:0]  off4, grid4, t_rep, rep_dist, tgt_clamp, cnt_diff;
  logic [1:0]     rep_off;
  logic [XW-1:0]  sub_a, sub_b, sub_diff;
  logic           sub_borrow;
  logic [RB:0]    shifted;

  assign n_eff = (32'(cfg.stop_count) > NUM_STOPS) ? NW'(NUM_STOPS) : NW'(cfg.stop_count);

  assign cur_x  = XW'(column);
  assign base_x = XW'(base);
  assign rs_x   = XW'(cfg.repeat_start);
  assign step_x = (cfg.repeat_step == '0) ? XW'(1) : XW'(cfg.repeat_step);
  assign stop_x = XW'(stops[idx]);

  // width-4 grid counted from the base, strictly above the column
  assign off4  = cur_x - base_x;
  assign grid4 = (base_x > cur_x) ? base_x
               : cur_x - XW'(off4[1:0]) + XW'(tabx_pkg::BASE_GRID);

  // first width-4 grid point at or above the repeat start
  assign rep_off  = base[1:0] - cfg.repeat_start[1:0];
  assign t_rep    = (base_x < rs_x) ? rs_x + XW'(rep_off) : base_x;
  assign rep_dist = cur_x - t_rep;

  assign tgt_clamp = (target > COL_MAX_X) ? COL_MAX_X : target;
  assign cnt_diff  = tgt_clamp - cur_x;

  assign shifted = {rem, dq[CW-1]};

  always_comb begin
    sub_a = cur_x;
    sub_b = stop_x;
    if (state == S_DIV) begin
      sub_a = XW'(shifted);
      sub_b = step_x;
    end
  end

  tabx_sub #(.W(XW)) u_sub (
    .a      (sub_a),
    .b      (sub_b),
    .diff   (sub_diff),
    .borrow (sub_borrow)
  );

  assign in_ready  = (state == S_IDLE) && !done;
  assign res_valid = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      done   <= 1'b0;
      column <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (done) begin
            if (res_take) begin
              done <= 1'b0;
            end
          end else if (in_valid) begin
            res.ch    <= in_char;
            res.count <= tabx_pkg::COUNT_BITS'(1);
            res.sat   <= 1'b0;
            if (in_char == tabx_pkg::TAB_CHAR) begin
              idx  <= '0;
              base <= '0;
              state <= (n_eff == '0) ? S_GRID : S_SCAN;
            end else if (in_char == tabx_pkg::NEWLINE_CHAR) begin
              column <= '0;
              done   <= 1'b1;
            end else begin
              if (column == COL_MAX) begin
                res.sat <= 1'b1;
              end else begin
                column <= column + CW'(1);
              end
              done <= 1'b1;
            end
          end
        end
        S_SCAN: begin
          if (sub_borrow) begin
            target <= stop_x;
            state  <= S_FIN;
          end else if (NW'(idx) == n_eff - NW'(1)) begin
            base  <= stops[idx];
            state <= S_GRID;
          end else begin
            idx <= idx + IW'(1);
          end
        end
        S_GRID: begin
          if (cur_x < rs_x) begin
            target <= grid4;
            state  <= S_FIN;
          end else if (t_rep > cur_x) begin
            target <= t_rep;
            state  <= S_FIN;
          end else begin
            dq    <= rep_dist[CW-1:0];
            rem   <= '0;
            cnt   <= BW'(CW - 1);
            state <= S_DIV;
          end
        end
        S_DIV: begin
          // one remainder bit per cycle
          rem <= sub_borrow ? shifted[RB-1:0] : sub_diff[RB-1:0];
          dq  <= dq << 1;
          cnt <= cnt - BW'(1);
          if (cnt == '0) begin
            state <= S_ADJ;
          end
        end
        S_ADJ: begin
          target <= cur_x - XW'(rem) + step_x;
          state  <= S_FIN;
        end
        S_FIN: begin
          res.ch    <= tabx_pkg::SPACE_CHAR;
          res.count <= cnt_diff[tabx_pkg::COUNT_BITS-1:0];
          res.sat   <= (target > COL_MAX_X);
          column    <= tgt_clamp[CW-1:0];
          done      <= 1'b1;
          state     <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ design/tab_expander_stop_table.sv @@
// ----------------------------------------------------------------------------
// tab_expander_stop_table: tab expander with explicit and grid tab stops
// Expands each tab byte into a count of spaces up to the next tab stop.
// ----------------------------------------------------------------------------
// Usage:
//   Text bytes enter on the s_axis channel, one byte per item. Each byte
//   gives exactly one item on m_axis: the byte to emit, how many times to
//   emit it in a row, and a flag set when the column clamped at its maximum.
//   A tab turns into spaces; a newline passes and returns the column to 0.
//   Flow: a plain byte sets the sequencer's done flag, which loads the output
//   register and so raises m_axis_tvalid; the next byte is taken only once
//   that result has left the sequencer. A tab walks the explicit stops one
//   per cycle, then for the repeating grid runs a bit-serial remainder, one
//   bit of the column per cycle, through the shared subtractor.
//   The output register holds a finished item while m_axis_tready is low; the
//   sequencer then parks its next result and stops taking bytes until the
//   register frees up. Nothing is dropped.
//   Configuration must go through cfg_we/cfg_index/cfg_data while the block is
//   idle; the block does not enforce this. Reset (rst, synchronous) clears the
//   column, stop list and count, and sets repeat start 2000 and step 4.
// ----------------------------------------------------------------------------
module tab_expander_stop_table #(
  parameter int NUM_STOPS   = tabx_pkg::NUM_STOPS_DEF,
  parameter int COLUMN_BITS = tabx_pkg::COLUMN_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // input byte stream
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [tabx_pkg::IN_TDATA_BITS-1:0]     s_axis_tdata,   // [7:0] in_char
  // output stream
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // [7:0] out_char, [19:8] out_count, [20] column_saturated, [23:21] zero
  output logic [tabx_pkg::OUT_TDATA_BITS-1:0]    m_axis_tdata,
  // configuration writes
  input  logic                                   cfg_we,
  input  logic [tabx_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [tabx_pkg::REG_BITS-1:0]          cfg_data
);

  localparam int PAD_BITS = tabx_pkg::OUT_TDATA_BITS - $bits(tabx_pkg::res_t);

  logic [NUM_STOPS-1:0][tabx_pkg::REG_BITS-1:0] stops;
  tabx_pkg::cfg_t cfg;
  tabx_pkg::res_t res;
  logic           res_valid;
  logic           res_take;

  // Configuration registers. Only the stop registers below NUM_STOPS exist;
  // writes to stop indexes past them are dropped, as are unknown indexes.
  always_ff @(posedge clk) begin
    if (rst) begin
      stops            <= '0;
      cfg.stop_count   <= '0;
      cfg.repeat_start <= tabx_pkg::REPEAT_START_RST;
      cfg.repeat_step  <= tabx_pkg::REPEAT_STEP_RST;
    end else if (cfg_we) begin
      for (int i = 0; i < NUM_STOPS; i++) begin
        if (i < tabx_pkg::NUM_STOP_REGS) begin
          if (cfg_index == tabx_pkg::REG_STOP_0 + tabx_pkg::CFG_INDEX_BITS'(i)) begin
            stops[i] <= cfg_data;
          end
        end
      end
      case (cfg_index)
        tabx_pkg::REG_STOP_COUNT: begin
          cfg.stop_count <= cfg_data[tabx_pkg::STOP_CNT_BITS-1:0];
        end
        tabx_pkg::REG_REPEAT_START: begin
          cfg.repeat_start <= cfg_data;
        end
        tabx_pkg::REG_REPEAT_STEP: begin
          cfg.repeat_step <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  // Sequencer: holds the column and works out one result per byte.
  tabx_seq #(
    .NUM_STOPS   (NUM_STOPS),
    .COLUMN_BITS (COLUMN_BITS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_char   (s_axis_tdata[tabx_pkg::CHAR_BITS-1:0]),
    .stops     (stops),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  // Output register: load when empty or being drained this cycle.
  assign res_take = res_valid && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_take) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      m_axis_tdata <= {{PAD_BITS{1'b0}}, res};
    end
  end

  // An accepted byte keeps the sequencer busy, so s_axis_tready is low in the cycle after the accept.
  assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted twice in a row");

  // A zero count only comes from a tab that hit the column maximum.
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tdata[19:8] == '0)) |-> m_axis_tdata[20])
    else $error("zero count without saturation");

  // Anything but an expanded tab goes out exactly once.
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tdata[7:0] != tabx_pkg::SPACE_CHAR))
      |-> (m_axis_tdata[19:8] == 12'd1))
    else $error("plain byte with count other than one");

endmodule
